[hw/rtl/servo_pulse_sequencer_core_defines.svh]
// Assertion macros for the servo pulse sequencer core
`ifndef SERVO_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define SERVO_PULSE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo sequencer check failed");
`define SPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo sequencer check failed");
`else
`define SPC_ASSERT_SAME(lbl, ante, cons)
`define SPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/spc_pkg.sv]
package spc_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int NC_W     = CH_W + 1;
  localparam int WIDTH_W  = 16;
  localparam int REM_W    = WIDTH_W + 1;
  localparam int FRAME_W  = 20;
  localparam int LINES_W  = 8;

  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(144000);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

endpackage

[hw/rtl/spc_ram.sv]
module spc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/servo_pulse_sequencer_core.sv]
// channel | signals                            | handshake
// config  | cfg_we, cfg_wdata                  | write enable, no wait
// request | func, channel, width               | in_valid / in_ready
// result  | pulse_lines, read_width, frame_st. | out_valid / out_ready
//
// One request per cycle unless stalled; results pass resolve and output registers.
// Width memory has one read port; the next channel address is forwarded from the
// resolve stage into the read of the following request.
// Synchronous reset, no clearing pass: per-channel valid bits make widths read as 0.
// A stalled result holds the resolve stage and, behind it, request acceptance.
`include "servo_pulse_sequencer_core_defines.svh"

module servo_pulse_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spc_pkg::FRAME_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [spc_pkg::CH_W-1:0]      channel,
  input  logic [spc_pkg::WIDTH_W-1:0]   width,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spc_pkg::LINES_W-1:0]   pulse_lines,
  output logic [spc_pkg::WIDTH_W-1:0]   read_width,
  output logic                          frame_start
);
  import spc_pkg::*;

  logic [FRAME_W-1:0]  frame_ticks;
  logic [FRAME_W-1:0]  frame_count;
  logic [FRAME_W:0]    frame_sum;
  logic                rewind_now;
  logic                accept;
  func_t               in_func;

  logic                s1_valid;
  func_t               s1_func;
  logic                s1_rewind;
  logic                s1_hit;
  logic                s1_adv;

  logic [CHANNELS-1:0] wvalid;
  logic                ram_we;
  logic [CH_W-1:0]     ram_raddr;
  logic [WIDTH_W-1:0]  ram_rdata;
  logic [WIDTH_W-1:0]  w_eff;

  logic [NC_W-1:0]     next_channel;
  logic [NC_W-1:0]     next_channel_next;
  logic [NC_W-1:0]     nc0;
  logic                pulse_active;
  logic                pulse_active_next;
  logic [CH_W-1:0]     pulse_channel;
  logic [CH_W-1:0]     pulse_channel_next;
  logic [REM_W-1:0]    pulse_remaining;
  logic [REM_W-1:0]    pulse_remaining_next;
  logic [REM_W-1:0]    rem_dec;
  logic                pa_after;
  logic [LINES_W-1:0]  lines_next;

  assign in_func    = func_t'(func);
  assign accept     = in_valid && in_ready;
  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_adv;
  assign frame_sum  = {1'b0, frame_count} + (FRAME_W + 1)'(1);
  assign rewind_now = frame_sum >= {1'b0, frame_ticks};
  assign ram_we     = accept && (in_func == FUNC_WRITE);
  assign w_eff      = s1_hit ? ram_rdata : '0;

  always_comb begin
    if (in_func == FUNC_READ) begin
      ram_raddr = channel;
    end else if (rewind_now) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = next_channel_next[CH_W-1:0];
    end
  end

  spc_ram #(
    .WIDTH (WIDTH_W),
    .DEPTH (CHANNELS)
  ) u_width_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (channel),
    .wdata (width),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // resolve the tick in stage 1
  always_comb begin
    next_channel_next    = next_channel;
    pulse_active_next    = pulse_active;
    pulse_channel_next   = pulse_channel;
    pulse_remaining_next = pulse_remaining;
    rem_dec  = (pulse_remaining != '0) ? pulse_remaining - REM_W'(1) : pulse_remaining;
    pa_after = pulse_active && (rem_dec != '0);
    nc0      = s1_rewind ? '0 : next_channel;
    if (s1_adv && (s1_func == FUNC_TICK)) begin
      pulse_active_next = pa_after;
      next_channel_next = nc0;
      if (pulse_active) begin
        pulse_remaining_next = rem_dec;
      end
      if ((nc0 < NC_W'(CHANNELS)) && !pa_after) begin
        if (w_eff != '0) begin
          pulse_active_next    = 1'b1;
          pulse_channel_next   = nc0[CH_W-1:0];
          pulse_remaining_next = {1'b0, w_eff} + REM_W'(1);
        end
        next_channel_next = nc0 + NC_W'(1);
      end
    end
  end

  always_comb begin
    lines_next = '0;
    if (pulse_active_next) begin
      lines_next[pulse_channel_next] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks     <= FRAME_RESET;
      frame_count     <= '0;
      wvalid          <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      next_channel    <= '0;
      pulse_active    <= 1'b0;
      pulse_channel   <= '0;
      pulse_remaining <= '0;
    end else begin
      if (cfg_we) begin
        frame_ticks <= cfg_wdata;
      end
      if (accept && (in_func == FUNC_TICK)) begin
        frame_count <= rewind_now ? '0 : frame_sum[FRAME_W-1:0];
      end
      if (ram_we) begin
        wvalid[channel] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      next_channel    <= next_channel_next;
      pulse_active    <= pulse_active_next;
      pulse_channel   <= pulse_channel_next;
      pulse_remaining <= pulse_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func   <= in_func;
      s1_rewind <= rewind_now;
      s1_hit    <= wvalid[ram_raddr];
    end
    if (s1_adv) begin
      pulse_lines <= lines_next;
      read_width  <= (s1_func == FUNC_READ) ? w_eff : '0;
      frame_start <= (s1_func == FUNC_TICK) && s1_rewind;
    end
  end

  `SPC_ASSERT_SAME(a_lines_onehot, out_valid, $onehot0(pulse_lines))
  `SPC_ASSERT_SAME(a_active_has_count, pulse_active, pulse_remaining != '0)
  `SPC_ASSERT_SAME(a_channel_bound, 1'b1, next_channel <= NC_W'(CHANNELS))
  `SPC_ASSERT_SAME(a_frame_no_read, out_valid && frame_start, read_width == '0)
  `SPC_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_func))

endmodule
